FILE: rtl/core/gwwp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwp_pkg
// Shared types, codes and defaults of the greedy word-wrap paginator.
// ----------------------------------------------------------------------------
package gwwp_pkg;

	localparam int LINE_BUFFER_DEF = 64;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LINE_CHARS = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LINES_PER_PAGE = 1'd1;

	localparam logic [7:0] MAX_LINE_CHARS_RST = 8'd40;
	localparam logic [7:0] LINES_PER_PAGE_RST = 8'd20;

	localparam logic [7:0] CHAR_TAB     = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_SPACE   = 8'd32;

	localparam logic [15:0] PAGE_LIMIT = 16'hFFFF;

	localparam logic [1:0] CLS_WORD    = 2'd0;
	localparam logic [1:0] CLS_BLANK   = 2'd1;
	localparam logic [1:0] CLS_NEWLINE = 2'd2;

	typedef struct packed {
		logic [1:0] cls;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] page_offset;
		logic [15:0] page_number;
		logic        is_summary;
		logic        page_overflow;
		logic        last_result;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/core/gwwp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwp_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module gwwp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/gwwp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwp_front
// Input stage: registers each byte, classifies it and feeds the item queue.
// ----------------------------------------------------------------------------
module gwwp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [7:0]    text_byte,
	input  wire logic          final_byte,
	output logic               full,
	output logic               q_push,
	output gwwp_pkg::item_t    q_item,
	input  wire logic          q_full
);

	logic            valid_s1;
	gwwp_pkg::item_t item_s1;
	gwwp_pkg::item_t item_in;
	logic            take;

	always_comb begin
		item_in.final_byte = final_byte;
		if (text_byte == gwwp_pkg::CHAR_NEWLINE) begin
			item_in.cls = gwwp_pkg::CLS_NEWLINE;
		end else if (text_byte == gwwp_pkg::CHAR_SPACE || text_byte == gwwp_pkg::CHAR_TAB) begin
			item_in.cls = gwwp_pkg::CLS_BLANK;
		end else begin
			item_in.cls = gwwp_pkg::CLS_WORD;
		end
	end

	assign full   = valid_s1 && q_full;
	assign take   = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/gwwp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwp_back
// Line and page tracker: applies greedy word wrap to classified items,
// holds the configuration registers and produces page and summary results.
// ----------------------------------------------------------------------------
module gwwp_back #(
	parameter int LINE_BUFFER = gwwp_pkg::LINE_BUFFER_DEF,
	parameter int OFFSET_BITS = gwwp_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [gwwp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [7:0]                          cfg_data,
	input  wire logic                                item_valid,
	input  wire gwwp_pkg::item_t                     item,
	output logic                                     item_pop,
	output logic                                     res_push,
	output gwwp_pkg::res_t                           res_data,
	input  wire logic                                res_full
);

	localparam int LW = $clog2(LINE_BUFFER);
	localparam int WW = LW + 1;
	localparam int SW = LW + 2;
	localparam int OB = OFFSET_BITS;

	logic [7:0]    max_q;
	logic [7:0]    lpp_q;
	logic [OB-1:0] pos_q;
	logic [OB-1:0] wstart_q;
	logic [LW-1:0] line_q;
	logic [WW-1:0] word_q;
	logic [7:0]    lop_q;
	logic [15:0]   ptot_q;
	logic          ovf_q;
	logic          sum_pend_q;
	logic [15:0]   sum_pages_q;
	logic          sum_ovf_q;

	logic [LW-1:0] limit;
	logic [7:0]    lpp_eff;
	logic [SW-1:0] place_sum;
	logic [LW-1:0] placed;
	logic [OB-1:0] pos_inc;
	logic [OB-1:0] ws;
	logic [WW-1:0] wl;
	logic [SW-1:0] fit_sum;
	logic          is_nl;
	logic [OB-1:0] brk;
	logic          done;
	logic [LW-1:0] line_n;
	logic [WW-1:0] word_n;
	logic [OB-1:0] wstart_n;
	logic [7:0]    lop1;
	logic          page_hit;
	logic          emit_page;
	logic          ovf_set;
	logic [15:0]   ptot_n;
	logic          ovf_n;
	logic          need_push;
	logic          go;
	gwwp_pkg::res_t page_res;
	gwwp_pkg::res_t sum_res;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (max_q == 8'd0) begin
			limit = LW'(1);
		end else if (max_q > 8'(LINE_BUFFER - 1)) begin
			limit = LW'(LINE_BUFFER - 1);
		end else begin
			limit = max_q[LW-1:0];
		end
		lpp_eff = (lpp_q == 8'd0) ? 8'd1 : lpp_q;
	end

	assign place_sum = SW'(line_q) + SW'(line_q != '0) + SW'(word_q);
	assign placed    = (place_sum > SW'(LINE_BUFFER - 1)) ? LW'(LINE_BUFFER - 1)
	                                                      : place_sum[LW-1:0];
	assign pos_inc   = pos_q + 1'b1;
	assign ws        = (word_q == '0) ? pos_q : wstart_q;
	assign wl        = word_q + 1'b1;
	assign fit_sum   = SW'(line_q) + SW'(1) + SW'(wl);
	assign is_nl     = (item.cls == gwwp_pkg::CLS_NEWLINE);

	always_comb begin
		line_n   = line_q;
		word_n   = word_q;
		wstart_n = wstart_q;
		brk      = '0;
		done     = 1'b0;
		case (item.cls)
			gwwp_pkg::CLS_NEWLINE: begin
				line_n = '0;
				word_n = '0;
				brk    = pos_inc;
				done   = 1'b1;
			end
			gwwp_pkg::CLS_BLANK: begin
				if (word_q != '0) begin
					line_n = placed;
					word_n = '0;
				end
			end
			gwwp_pkg::CLS_WORD: begin
				wstart_n = ws;
				word_n   = wl;
				if (line_q != '0 && fit_sum > SW'(limit)) begin
					brk    = ws;
					line_n = '0;
					done   = 1'b1;
				end else if (line_q == '0 && wl > WW'(limit)) begin
					brk      = ws + OB'(limit);
					wstart_n = ws + OB'(limit);
					word_n   = wl - WW'(limit);
					done     = 1'b1;
				end
			end
			default: begin
				line_n = line_q;
			end
		endcase
	end

	assign lop1      = lop_q + 8'd1;
	assign page_hit  = done && (lop1 >= lpp_eff) && !(item.final_byte && is_nl);
	assign emit_page = page_hit && (ptot_q != gwwp_pkg::PAGE_LIMIT);
	assign ovf_set   = page_hit && (ptot_q == gwwp_pkg::PAGE_LIMIT);
	assign ptot_n    = ptot_q + 16'(emit_page);
	assign ovf_n     = ovf_q || ovf_set;
	assign need_push = emit_page || item.final_byte;
	assign go        = !sum_pend_q && item_valid && (!need_push || !res_full);
	assign item_pop  = go;

	always_comb begin
		page_res.page_offset   = 32'(brk);
		page_res.page_number   = ptot_q;
		page_res.is_summary    = 1'b0;
		page_res.page_overflow = 1'b0;
		page_res.last_result   = !item.final_byte;
		sum_res.page_offset    = '0;
		sum_res.page_number    = sum_pend_q ? sum_pages_q : ptot_n;
		sum_res.is_summary     = 1'b1;
		sum_res.page_overflow  = sum_pend_q ? sum_ovf_q : ovf_n;
		sum_res.last_result    = 1'b1;
	end

	assign res_push = sum_pend_q ? !res_full : (go && need_push);
	assign res_data = (!sum_pend_q && emit_page) ? page_res : sum_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= gwwp_pkg::MAX_LINE_CHARS_RST;
			lpp_q <= gwwp_pkg::LINES_PER_PAGE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gwwp_pkg::CFG_MAX_LINE_CHARS: max_q <= cfg_data;
				gwwp_pkg::CFG_LINES_PER_PAGE: lpp_q <= cfg_data;
				default: max_q <= max_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			wstart_q   <= '0;
			line_q     <= '0;
			word_q     <= '0;
			lop_q      <= '0;
			ptot_q     <= 16'd1;
			ovf_q      <= 1'b0;
			sum_pend_q <= 1'b0;
		end else if (sum_pend_q) begin
			if (!res_full) begin
				sum_pend_q <= 1'b0;
			end
		end else if (go) begin
			if (item.final_byte) begin
				pos_q      <= '0;
				wstart_q   <= '0;
				line_q     <= '0;
				word_q     <= '0;
				lop_q      <= '0;
				ptot_q     <= 16'd1;
				ovf_q      <= 1'b0;
				sum_pend_q <= emit_page;
			end else begin
				pos_q    <= pos_inc;
				wstart_q <= wstart_n;
				line_q   <= line_n;
				word_q   <= word_n;
				lop_q    <= (done && lop1 >= lpp_eff) ? 8'd0 : (done ? lop1 : lop_q);
				ptot_q   <= ptot_n;
				ovf_q    <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && item.final_byte) begin
			sum_pages_q <= ptot_n;
			sum_ovf_q   <= ovf_n;
		end
	end

`ifndef SYNTHESIS
	a_pend_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		sum_pend_q |-> !item_pop) else $error("item taken while a summary is pending");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into a full queue");
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item.final_byte) |=> (pos_q == '0 && ptot_q == 16'd1 && lop_q == 8'd0))
		else $error("document state not cleared after the final byte");
	a_pend_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		sum_pend_q |-> (ptot_q == 16'd1 && word_q == '0))
		else $error("summary pending while a document is in progress");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/greedy_word_wrap_paginator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_word_wrap_paginator_unit
// Breaks a byte stream into lines by greedy word wrap and reports the byte
// offset of every page start, plus a page count at the end of each document.
//
//   Channel  Handshake          Payload
//   input    push / full        text_byte, final_byte
//   result   pop / empty        page_offset, page_number, is_summary,
//                               page_overflow, last_result
//   config   cfg_valid/ready    cfg_index, cfg_data
//
// One byte per cycle is sustained while the result queue has room; a final
// byte that also starts a page holds the line tracker until its summary is pushed.
// A byte passes the input register and item queue; its results, the result queue.
// Reset sets max_line_chars to 40, lines_per_page to 20 and a fresh document.
// A small item queue lets input and result stalls proceed independently.
// ----------------------------------------------------------------------------
module greedy_word_wrap_paginator_unit #(
	parameter int LINE_BUFFER = gwwp_pkg::LINE_BUFFER_DEF,
	parameter int OFFSET_BITS = gwwp_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = gwwp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [7:0]                          text_byte,
	input  wire logic                                final_byte,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [31:0]                              page_offset,
	output logic [15:0]                              page_number,
	output logic                                     is_summary,
	output logic                                     page_overflow,
	output logic                                     last_result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [gwwp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [7:0]                          cfg_data
);

	localparam int IW = $bits(gwwp_pkg::item_t);
	localparam int RW = $bits(gwwp_pkg::res_t);

	logic            fq_push;
	gwwp_pkg::item_t fq_item;
	logic            fq_full;
	logic            iq_empty;
	logic [IW-1:0]   iq_dout;
	logic            item_pop;
	logic            res_push;
	gwwp_pkg::res_t  res_data;
	logic            res_full;
	logic [RW-1:0]   rq_dout;
	gwwp_pkg::res_t  head;

	gwwp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.full       (full),
		.q_push     (fq_push),
		.q_item     (fq_item),
		.q_full     (fq_full)
	);

	gwwp_fifo #(
		.WIDTH (IW),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_item),
		.full   (fq_full),
		.pop    (item_pop),
		.dout   (iq_dout),
		.empty  (iq_empty)
	);

	gwwp_back #(
		.LINE_BUFFER (LINE_BUFFER),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (!iq_empty),
		.item       (gwwp_pkg::item_t'(iq_dout)),
		.item_pop   (item_pop),
		.res_push   (res_push),
		.res_data   (res_data),
		.res_full   (res_full)
	);

	gwwp_fifo #(
		.WIDTH (RW),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_data),
		.full   (res_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign head          = gwwp_pkg::res_t'(rq_dout);
	assign page_offset   = head.page_offset;
	assign page_number   = head.page_number;
	assign is_summary    = head.is_summary;
	assign page_overflow = head.page_overflow;
	assign last_result   = head.last_result;

endmodule
`default_nettype wire

FILE: tb/sv/tb_greedy_word_wrap_paginator_unit.sv
// ----------------------------------------------------------------------------
// tb_greedy_word_wrap_paginator_unit
// Self-checking bench for the greedy word-wrap paginator. A directed table of
// bytes comes first, then random documents under several register settings.
// Each accepted byte is run through a local model of the line and page
// tracking, and every popped result is compared with the oldest expected one.
// Both sides of the queue interface stall at random.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap_paginator_unit;

	import gwwp_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		res_t       want;
	} probe_row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_item_t;

	localparam res_t LONE_SUMMARY = '{32'd0, 16'd1, 1'b1, 1'b0, 1'b1};
	localparam res_t NO_RESULT = '0;

	localparam int PROBE_COUNT = 21;
	localparam int RETUNE_AT = 3;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 216;
	localparam int SETTLE_CYCLES = 16;

	localparam probe_row_t PROBES [PROBE_COUNT] = '{
		'{8'h41, 1'b1, 1'b1, LONE_SUMMARY},
		'{8'h0A, 1'b1, 1'b1, LONE_SUMMARY},
		'{8'h20, 1'b1, 1'b1, LONE_SUMMARY},
		'{8'h0A, 1'b1, 1'b1, LONE_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h20, 1'b0, 1'b0, NO_RESULT},
		'{8'h09, 1'b0, 1'b0, NO_RESULT},
		'{8'h62, 1'b0, 1'b0, NO_RESULT},
		'{8'h0A, 1'b0, 1'b0, NO_RESULT},
		'{8'h7F, 1'b0, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, 1'b0, NO_RESULT},
		'{8'h0B, 1'b0, 1'b0, NO_RESULT},
		'{8'h1F, 1'b0, 1'b0, NO_RESULT},
		'{8'h21, 1'b0, 1'b0, NO_RESULT},
		'{8'h0A, 1'b1, 1'b0, NO_RESULT},
		'{8'h09, 1'b0, 1'b0, NO_RESULT},
		'{8'h20, 1'b0, 1'b0, NO_RESULT},
		'{8'h55, 1'b0, 1'b0, NO_RESULT},
		'{8'hAA, 1'b1, 1'b0, NO_RESULT},
		'{8'h01, 1'b1, 1'b1, LONE_SUMMARY}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic [7:0]                text_byte = '0;
	logic                      final_byte = 1'b0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic [31:0]               page_offset;
	logic [15:0]               page_number;
	logic                      is_summary;
	logic                      page_overflow;
	logic                      last_result;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [7:0]                cfg_data = '0;

	logic [7:0]  wrap_width;
	logic [7:0]  page_height;
	logic [31:0] doc_pos;
	logic [5:0]  line_fill;
	logic [6:0]  word_fill;
	logic [31:0] word_origin;
	logic [7:0]  lines_this_page;
	logic [15:0] pages_counted;
	logic        pages_dropped;

	res_t       step_out [2];
	int         step_count;
	res_t       page_marks_due [$];
	text_item_t backlog [$];
	int         fault_count = 0;
	int         tx_calm = 0;
	int         rx_calm = 0;

	greedy_word_wrap_paginator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.text_byte    (text_byte),
		.final_byte   (final_byte),
		.empty        (empty),
		.pop          (pop),
		.page_offset  (page_offset),
		.page_number  (page_number),
		.is_summary   (is_summary),
		.page_overflow(page_overflow),
		.last_result  (last_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	task automatic fresh_document();
		doc_pos = '0;
		line_fill = '0;
		word_fill = '0;
		word_origin = '0;
		lines_this_page = '0;
		pages_counted = 16'd1;
		pages_dropped = 1'b0;
	endtask

	task automatic close_word();
		int span;
		span = int'(line_fill) + (line_fill != 0 ? 1 : 0) + int'(word_fill);
		if (span > LINE_BUFFER_DEF - 1) span = LINE_BUFFER_DEF - 1;
		line_fill = 6'(span);
		word_fill = '0;
	endtask

	task automatic wrap_byte(input logic [7:0] ch, input logic fin);
		int reach;
		int depth;
		logic [31:0] brk;
		bit line_done;
		step_count = 0;
		line_done = 1'b0;
		brk = '0;
		reach = (wrap_width == 0) ? 1 : int'(wrap_width);
		if (reach > LINE_BUFFER_DEF - 1) reach = LINE_BUFFER_DEF - 1;
		depth = (page_height == 0) ? 1 : int'(page_height);
		if (ch == CHAR_NEWLINE) begin
			if (word_fill != 0) close_word();
			line_fill = '0;
			brk = doc_pos + 32'd1;
			line_done = 1'b1;
		end else if (ch == CHAR_SPACE || ch == CHAR_TAB) begin
			if (word_fill != 0) close_word();
		end else begin
			if (word_fill == 0) word_origin = doc_pos;
			word_fill = word_fill + 7'd1;
			if (line_fill != 0 && int'(line_fill) + 1 + int'(word_fill) > reach) begin
				brk = word_origin;
				line_fill = '0;
				line_done = 1'b1;
			end else if (line_fill == 0 && int'(word_fill) > reach) begin
				brk = word_origin + 32'(reach);
				word_origin = brk;
				word_fill = 7'(int'(word_fill) - reach);
				line_done = 1'b1;
			end
		end
		if (line_done) begin
			lines_this_page = lines_this_page + 8'd1;
			if (int'(lines_this_page) >= depth) begin
				lines_this_page = '0;
				if (!(fin && ch == CHAR_NEWLINE)) begin
					if (pages_counted >= PAGE_LIMIT) begin
						pages_dropped = 1'b1;
					end else begin
						step_out[step_count] = '{brk, pages_counted, 1'b0, 1'b0, 1'b1};
						step_count++;
						pages_counted = pages_counted + 16'd1;
					end
				end
			end
		end
		doc_pos = doc_pos + 32'd1;
		if (fin) begin
			if (step_count > 0) step_out[step_count - 1].last_result = 1'b0;
			step_out[step_count] = '{32'd0, pages_counted, 1'b1, pages_dropped, 1'b1};
			step_count++;
			fresh_document();
		end
	endtask

	task automatic send_byte(input logic [7:0] ch, input logic fin, input logic typed,
			input res_t want);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		text_byte <= ch;
		final_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		wrap_byte(ch, fin);
		if (typed) begin
			page_marks_due.push_back(want);
		end else begin
			for (int k = 0; k < step_count; k++) page_marks_due.push_back(step_out[k]);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (page_marks_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] width, input logic [7:0] height);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAX_LINE_CHARS;
		cfg_data <= width;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		wrap_width = width;
		cfg_index <= CFG_LINES_PER_PAGE;
		cfg_data <= height;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		page_height = height;
		cfg_valid <= 1'b0;
	endtask

	task automatic feed_random(input int quota);
		int sent;
		int words;
		int span;
		int roll;
		logic [7:0] ch;
		text_item_t item;
		sent = 0;
		while (sent < quota) begin
			if (backlog.size() == 0) begin
				if ($urandom_range(0, 3) == 0) backlog.push_back('{CHAR_SPACE, 1'b0});
				words = $urandom_range(1, 10);
				for (int w = 0; w < words; w++) begin
					span = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 90)
						: $urandom_range(1, 9);
					for (int k = 0; k < span; k++) begin
						do ch = 8'($urandom_range(0, 255));
						while (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_NEWLINE);
						backlog.push_back('{ch, 1'b0});
					end
					roll = $urandom_range(0, 19);
					if (roll < 11) begin
						repeat ($urandom_range(1, 3))
							backlog.push_back(
								'{($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB), 1'b0});
					end else if (roll < 17) begin
						repeat ($urandom_range(1, 2)) backlog.push_back('{CHAR_NEWLINE, 1'b0});
					end else if (roll < 19) begin
						backlog.push_back('{8'($urandom_range(0, 255)), 1'b0});
					end
				end
				if ($urandom_range(0, 5) == 0) backlog.push_back('{CHAR_NEWLINE, 1'b0});
				backlog[backlog.size() - 1].fin = 1'b1;
			end
			item = backlog.pop_front();
			send_byte(item.ch, item.fin, 1'b0, NO_RESULT);
			sent++;
			if (item.fin && $urandom_range(0, 49) == 0) settle();
		end
	endtask

	initial begin : stimulus
		logic [7:0] width;
		logic [7:0] height;
		wrap_width = MAX_LINE_CHARS_RST;
		page_height = LINES_PER_PAGE_RST;
		fresh_document();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_COUNT; i++) begin
			if (i == RETUNE_AT) begin
				settle();
				program_regs(8'd0, 8'd0);
			end
			send_byte(PROBES[i].ch, PROBES[i].fin, PROBES[i].typed, PROBES[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin width = 8'd1;   height = 8'd1;   end
				1: begin width = 8'd63;  height = 8'd2;   end
				2: begin width = 8'd64;  height = 8'd255; end
				3: begin width = 8'd255; height = 8'd3;   end
				4: begin width = 8'd12;  height = 8'd0;   end
				default: begin
					width = 8'($urandom_range(2, 24));
					height = 8'($urandom_range(1, 5));
				end
			endcase
			settle();
			program_regs(width, height);
			feed_random(PHASE_ITEMS);
		end

		settle();
		if (fault_count == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin : drain_results
		int gap;
		res_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap(rx_calm);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (page_marks_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: off=%0d page=%0d sum=%0b ovf=%0b last=%0b",
						page_offset, page_number, is_summary, page_overflow, last_result);
			end else begin
				want = page_marks_due.pop_front();
				if (page_offset !== want.page_offset || page_number !== want.page_number ||
						is_summary !== want.is_summary || page_overflow !== want.page_overflow ||
						last_result !== want.last_result) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result mismatch: want off=%0d page=%0d sum=%0b ovf=%0b last=%0b,",
							want.page_offset, want.page_number, want.is_summary,
							want.page_overflow, want.last_result,
							" got off=%0d page=%0d sum=%0b ovf=%0b last=%0b",
							page_offset, page_number, is_summary, page_overflow,
							last_result);
				end
			end
		end
	end

	initial begin : watchdog
		#12_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: greedy_word_wrap_paginator_unit.f
rtl/core/gwwp_pkg.sv
rtl/core/gwwp_fifo.sv
rtl/core/gwwp_front.sv
rtl/core/gwwp_back.sv
rtl/core/greedy_word_wrap_paginator_unit.sv
tb/sv/tb_greedy_word_wrap_paginator_unit.sv
